/* hdl/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the bitmap change classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // word modes
  localparam logic [1:0] MODE_OLD   = 2'd0;
  localparam logic [1:0] MODE_NEW   = 2'd1;
  localparam logic [1:0] MODE_PIXEL = 2'd2;

  localparam int unsigned DIM_W  = 13;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned LEFT_W = 25;
  localparam int unsigned PROD_W = 2 * DIM_W;

  localparam logic [LEFT_W-1:0] LEFT_MAX  = {LEFT_W{1'b1}};
  localparam logic [7:0]        TOL_RESET = 8'd20;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_POSITION = 2'd1,
    KIND_ALPHA    = 2'd2,
    KIND_CONTENT  = 2'd3
  } kind_e;

  // verdict of one pixel pair
  typedef struct packed {
    logic set_alpha;
    logic set_color;
  } pix_flags_t;

  function automatic kind_e final_kind(input logic color_diff, input logic alpha_diff,
                                       input logic moved);
    kind_e k;
    if (color_diff) begin
      k = KIND_CONTENT;
    end else if (!alpha_diff) begin
      k = moved ? KIND_POSITION : KIND_NONE;
    end else begin
      k = moved ? KIND_CONTENT : KIND_ALPHA;
    end
    return k;
  endfunction

endpackage

/* hdl/bitmap_change_classifier.sv */
// ----------------------------------------------------------------------------
// bitmap_change_classifier
// Classifies the change between two RGBA overlay bitmaps as none, position
// only, alpha only or content, from two descriptors and a pixel-pair run.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+---------------------------
//  in       | to block  | in_valid_i / in_stall_o| mode, descriptor, pixels
//  out      | from block| out_valid_o/out_stall_i| change_kind
//  cfg      | to block  | cfg_we_i               | colour tolerance
//
// One word per cycle sustained while the output is not stalled: a word sits in
// the input register, is judged by the core and its class (if any) lands in the
// output register.
// Reset clears the descriptor store, run counter, flags and both valid bits;
// the tolerance returns to 20.
// A stalled output register holds the input register, and in_stall_o rises
// only while both are full.
// ----------------------------------------------------------------------------
module bitmap_change_classifier import bcc_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       mode_i,
  input  logic             present_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  input  logic [PIX_W-1:0] old_pixel_i,
  input  logic [PIX_W-1:0] new_pixel_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       change_kind_o
);

  logic [7:0]       tol_q;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [1:0]       mode_q;
  logic             present_q;
  logic [POS_W-1:0] pos_x_q, pos_y_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [PIX_W-1:0] old_pixel_q, new_pixel_q;

  // output register
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q;

  logic             advance, accept, go;
  logic             res_valid;
  kind_e            res_kind;

  // the pipe moves whenever the output register is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign go         = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q      <= mode_i;
      present_q   <= present_i;
      pos_x_q     <= pos_x_i;
      pos_y_q     <= pos_y_i;
      width_q     <= width_i;
      height_q    <= height_i;
      old_pixel_q <= old_pixel_i;
      new_pixel_q <= new_pixel_i;
    end
    if (advance && res_valid) begin
      kind_q <= res_kind;
    end
  end

  bcc_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .go_i        (go),
    .mode_i      (mode_q),
    .present_i   (present_q),
    .pos_x_i     (pos_x_q),
    .pos_y_i     (pos_y_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .old_pixel_i (old_pixel_q),
    .new_pixel_i (new_pixel_q),
    .res_valid_o (res_valid),
    .res_kind_o  (res_kind)
  );

  assign out_valid_o   = out_valid_q;
  assign change_kind_o = kind_q;

endmodule

/* hdl/bcc_pix_cmp.sv */
// ----------------------------------------------------------------------------
// bcc_pix_cmp
// Compares one old/new RGBA pixel pair against the colour tolerance.
// ----------------------------------------------------------------------------
module bcc_pix_cmp import bcc_pkg::*; (
  input  logic [PIX_W-1:0] old_pixel_i,
  input  logic [PIX_W-1:0] new_pixel_i,
  input  logic [7:0]       tol_i,
  output pix_flags_t       flags_o
);

  logic [7:0] a0, a1;
  logic [2:0] chan_over;

  assign a0 = old_pixel_i[31:24];
  assign a1 = new_pixel_i[31:24];

  // per-channel absolute difference, R G B
  always_comb begin
    logic [7:0] c0, c1, d;
    for (int i = 0; i < 3; i++) begin
      c0 = old_pixel_i[8*i +: 8];
      c1 = new_pixel_i[8*i +: 8];
      d  = (c0 > c1) ? (c0 - c1) : (c1 - c0);
      chan_over[i] = d > tol_i;
    end
  end

  always_comb begin
    flags_o = '0;
    if (a0 == 8'd0 && a1 == 8'd0) begin
      flags_o = '0;
    end else if (a0 == 8'd0 || a1 == 8'd0) begin
      flags_o.set_alpha = 1'b1;
    end else if (|chan_over) begin
      flags_o.set_color = 1'b1;
    end else if (a0 != a1) begin
      flags_o.set_alpha = 1'b1;
    end
  end

endmodule

/* hdl/bcc_core.sv */
// ----------------------------------------------------------------------------
// bcc_core
// Descriptor store, pixel run counter and sticky flags; decides the class.
// ----------------------------------------------------------------------------
module bcc_core import bcc_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       tol_i,
  input  logic             go_i,
  input  logic [1:0]       mode_i,
  input  logic             present_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  input  logic [PIX_W-1:0] old_pixel_i,
  input  logic [PIX_W-1:0] new_pixel_i,
  output logic             res_valid_o,
  output kind_e            res_kind_o
);

  logic              old_present_q, old_present_d;
  logic [POS_W-1:0]  old_left_q, old_left_d, old_top_q, old_top_d;
  logic [DIM_W-1:0]  old_wide_q, old_wide_d, old_tall_q, old_tall_d;
  logic              moved_q, moved_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic              alpha_q, alpha_d, color_q, color_d;

  pix_flags_t        pflags;
  logic [DIM_W-1:0]  w_clamp, h_clamp;
  logic [PROD_W-1:0] count;
  logic [LEFT_W-1:0] count_sat;
  logic              moved_now, alpha_nx, color_nx;

  bcc_pix_cmp u_pix_cmp (
    .old_pixel_i (old_pixel_i),
    .new_pixel_i (new_pixel_i),
    .tol_i       (tol_i),
    .flags_o     (pflags)
  );

  // clamp each side to MAX_DIM, then saturate the area to the counter range
  always_comb begin
    w_clamp = (32'(width_i)  > MAX_DIM) ? DIM_W'(MAX_DIM) : width_i;
    h_clamp = (32'(height_i) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_i;
  end

  assign count     = PROD_W'(w_clamp) * PROD_W'(h_clamp);
  assign count_sat = (|count[PROD_W-1:LEFT_W]) ? LEFT_MAX : count[LEFT_W-1:0];
  assign moved_now = (old_left_q != pos_x_i) || (old_top_q != pos_y_i);

  // sticky flags only change until the colour flag is set
  assign color_nx = color_q | pflags.set_color;
  assign alpha_nx = color_q ? alpha_q : (alpha_q | pflags.set_alpha);

  always_comb begin
    old_present_d = old_present_q;
    old_left_d    = old_left_q;
    old_top_d     = old_top_q;
    old_wide_d    = old_wide_q;
    old_tall_d    = old_tall_q;
    moved_d       = moved_q;
    left_d        = left_q;
    alpha_d       = alpha_q;
    color_d       = color_q;
    res_valid_o   = 1'b0;
    res_kind_o    = KIND_NONE;
    if (go_i) begin
      case (mode_i)
        MODE_OLD: begin
          left_d        = '0;
          old_present_d = present_i;
          old_left_d    = pos_x_i;
          old_top_d     = pos_y_i;
          old_wide_d    = width_i;
          old_tall_d    = height_i;
        end
        MODE_NEW: begin
          left_d = '0;
          if (!old_present_q && !present_i) begin
            res_valid_o = 1'b1;
            res_kind_o  = KIND_NONE;
          end else if (!old_present_q || !present_i ||
                       old_wide_q != width_i || old_tall_q != height_i) begin
            res_valid_o = 1'b1;
            res_kind_o  = KIND_CONTENT;
          end else begin
            moved_d = moved_now;
            alpha_d = 1'b0;
            color_d = 1'b0;
            if (count_sat == '0) begin
              res_valid_o = 1'b1;
              res_kind_o  = final_kind(1'b0, 1'b0, moved_now);
            end else begin
              left_d = count_sat;
            end
          end
        end
        MODE_PIXEL: begin
          if (left_q != '0) begin
            alpha_d = alpha_nx;
            color_d = color_nx;
            left_d  = left_q - LEFT_W'(1);
            if (left_q == LEFT_W'(1)) begin
              res_valid_o = 1'b1;
              res_kind_o  = final_kind(color_nx, alpha_nx, moved_q);
            end
          end
        end
        default: begin
          // spare mode: dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_present_q <= 1'b0;
      old_left_q    <= '0;
      old_top_q     <= '0;
      old_wide_q    <= '0;
      old_tall_q    <= '0;
      moved_q       <= 1'b0;
      left_q        <= '0;
      alpha_q       <= 1'b0;
      color_q       <= 1'b0;
    end else begin
      old_present_q <= old_present_d;
      old_left_q    <= old_left_d;
      old_top_q     <= old_top_d;
      old_wide_q    <= old_wide_d;
      old_tall_q    <= old_tall_d;
      moved_q       <= moved_d;
      left_q        <= left_d;
      alpha_q       <= alpha_d;
      color_q       <= color_d;
    end
  end

endmodule

/* dv/bitmap_change_classifier_test.sv */
// ----------------------------------------------------------------------------
// bitmap_change_classifier_test
// Self-checking bench for the bitmap change classifier. A directed opening
// covers the absent, size-mismatch, empty-area and per-pixel alpha/colour
// cases. Randomised descriptor/pixel-run sequences follow under several
// colour tolerances, with stalls on both channels. Each accepted word is fed
// to a local model of the block, and every class it returns is checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitmap_change_classifier_test;
  import bcc_pkg::*;

  localparam int unsigned DIM_LIMIT  = 4096;
  // mode code the block must ignore
  localparam logic [1:0]  MODE_SPARE = 2'd3;

  // one input word as it sits on the ports
  typedef struct packed {
    logic [1:0]       mode;
    logic             present;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DIM_W-1:0] wide;
    logic [DIM_W-1:0] tall;
    logic [PIX_W-1:0] old_px;
    logic [PIX_W-1:0] new_px;
  } word_t;

  // flavours of generated pixel pair
  typedef enum int unsigned {
    PAIR_SAME,       // identical, alpha non-zero
    PAIR_CLEAR,      // both alphas zero
    PAIR_ONE_CLEAR,  // exactly one alpha zero
    PAIR_CLOSE,      // colours within tolerance, equal alpha
    PAIR_COLOUR,     // one channel beyond tolerance
    PAIR_ALPHA,      // colours within tolerance, alphas differ
    PAIR_NOISE       // anything at all
  } pair_kind_e;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] change_kind_o;
  word_t cur = '0;

  always #5 clk = ~clk;

  bitmap_change_classifier #(
    .MAX_DIM(DIM_LIMIT)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (cur.mode),
    .present_i    (cur.present),
    .pos_x_i      (cur.pos_x),
    .pos_y_i      (cur.pos_y),
    .width_i      (cur.wide),
    .height_i     (cur.tall),
    .old_pixel_i  (cur.old_px),
    .new_pixel_i  (cur.new_px),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .change_kind_o(change_kind_o)
  );

  // --------------------------------------------------------------------------
  // Model state: stored old descriptor, run counter and sticky flags, plus
  // our copy of the tolerance register.
  // --------------------------------------------------------------------------
  logic [7:0]       tolerance = TOL_RESET;
  logic             st_old_present = 1'b0;
  logic [POS_W-1:0] st_old_x = '0;
  logic [POS_W-1:0] st_old_y = '0;
  logic [DIM_W-1:0] st_old_w = '0;
  logic [DIM_W-1:0] st_old_h = '0;
  logic             st_moved = 1'b0;
  int unsigned      st_left = 0;
  logic             st_alpha = 1'b0;
  logic             st_colour = 1'b0;

  word_t       word_queue [$];   // words waiting for the driver
  kind_e       kinds_due [$];    // classes the block still owes us
  logic        word_taken = 1'b0;
  logic        kind_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        quiet_send = 1'b0;
  logic        quiet_recv = 1'b0;
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned kinds_checked = 0;
  int unsigned tol_writes = 0;
  int unsigned kind_seen [4] = '{default: 0};

  function automatic int unsigned byte_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic int unsigned fit_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_LIMIT) ? DIM_LIMIT : int'(d);
  endfunction

  function automatic kind_e run_verdict();
    if (st_colour) return KIND_CONTENT;
    if (!st_alpha) return st_moved ? KIND_POSITION : KIND_NONE;
    return st_moved ? KIND_CONTENT : KIND_ALPHA;
  endfunction

  // Apply one accepted word to the model; queue the class if one is due.
  function automatic void judge_word(input word_t w);
    int unsigned npix;
    logic [7:0]  a0;
    logic [7:0]  a1;
    case (w.mode)
      MODE_OLD: begin
        st_left        = 0;
        st_old_present = w.present;
        st_old_x       = w.pos_x;
        st_old_y       = w.pos_y;
        st_old_w       = w.wide;
        st_old_h       = w.tall;
      end
      MODE_NEW: begin
        st_left = 0;
        if (!st_old_present && !w.present) begin
          kinds_due.push_back(KIND_NONE);
        end else if (!st_old_present || !w.present || st_old_w != w.wide ||
                     st_old_h != w.tall) begin
          kinds_due.push_back(KIND_CONTENT);
        end else begin
          st_moved  = (st_old_x != w.pos_x) || (st_old_y != w.pos_y);
          st_alpha  = 1'b0;
          st_colour = 1'b0;
          npix = fit_dim(w.wide) * fit_dim(w.tall);
          if (npix == 0) begin
            kinds_due.push_back(run_verdict());
          end else begin
            st_left = (npix > LEFT_MAX) ? int'(LEFT_MAX) : npix;
          end
        end
      end
      MODE_PIXEL: begin
        if (st_left != 0) begin
          // once colour has changed, pixels only count down
          if (!st_colour) begin
            a0 = w.old_px[31:24];
            a1 = w.new_px[31:24];
            if (a0 != 8'd0 || a1 != 8'd0) begin
              if (a0 == 8'd0 || a1 == 8'd0) begin
                st_alpha = 1'b1;
              end else if (byte_gap(w.old_px[7:0], w.new_px[7:0]) > tolerance ||
                           byte_gap(w.old_px[15:8], w.new_px[15:8]) > tolerance ||
                           byte_gap(w.old_px[23:16], w.new_px[23:16]) > tolerance) begin
                st_colour = 1'b1;
              end else if (a0 != a1) begin
                st_alpha = 1'b1;
              end
            end
          end
          st_left--;
          if (st_left == 0) kinds_due.push_back(run_verdict());
        end
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_word(input logic [1:0] mode, input logic present,
                                    input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                    input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                    input logic [PIX_W-1:0] op, input logic [PIX_W-1:0] np);
    word_queue.push_back('{mode, present, x, y, w, h, op, np});
  endfunction

  // wait, in cycles, before the next word / after each taken class
  function automatic int unsigned draw_wait(input logic quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [DIM_W-1:0] small_dim();
    if ($urandom_range(0, 11) == 0) return '0;
    return DIM_W'($urandom_range(1, 4));
  endfunction

  // channel value within the current tolerance of a
  function automatic logic [7:0] near_byte(input logic [7:0] a);
    int unsigned d;
    int unsigned ai;
    d  = $urandom_range(0, tolerance);
    ai = a;
    if (ai + d <= 255 && ($urandom_range(0, 1) == 1 || ai < d)) return 8'(ai + d);
    if (ai >= d) return 8'(ai - d);
    return 8'd0;
  endfunction

  // mix bit 0 allows alpha changes, bit 1 colour changes; rare noise anyway
  function automatic pair_kind_e pick_kind(input logic [1:0] mix);
    pair_kind_e k;
    k = pair_kind_e'($urandom_range(PAIR_SAME, PAIR_ALPHA));
    if (!mix[0] && (k == PAIR_ONE_CLEAR || k == PAIR_ALPHA)) k = PAIR_CLOSE;
    if (!mix[1] && k == PAIR_COLOUR) k = PAIR_SAME;
    if ($urandom_range(0, 29) == 0) k = PAIR_NOISE;
    return k;
  endfunction

  // returns {old pixel, new pixel}
  function automatic logic [63:0] pixel_pair(input pair_kind_e k);
    logic [31:0] op;
    logic [31:0] np;
    int unsigned ch;
    int unsigned lo;
    int unsigned hi;
    op = $urandom();
    op[31:24] = 8'($urandom_range(1, 255));
    np = op;
    if (k == PAIR_CLOSE || k == PAIR_COLOUR || k == PAIR_ALPHA) begin
      for (int c = 0; c < 3; c++) np[8*c +: 8] = near_byte(op[8*c +: 8]);
    end
    case (k)
      PAIR_CLEAR: begin
        np = $urandom();
        op[31:24] = 8'd0;
        np[31:24] = 8'd0;
      end
      PAIR_ONE_CLEAR: begin
        np = $urandom();
        np[31:24] = 8'd0;
        if ($urandom_range(0, 1) == 1) {op, np} = {np, op};
      end
      PAIR_COLOUR: begin
        if (tolerance == 8'd255) begin
          np = $urandom();
        end else begin
          ch = $urandom_range(0, 2);
          lo = $urandom_range(0, 254 - tolerance);
          hi = $urandom_range(lo + tolerance + 1, 255);
          op[8*ch +: 8] = 8'(lo);
          np[8*ch +: 8] = 8'(hi);
          if ($urandom_range(0, 1) == 1) {op, np} = {np, op};
        end
      end
      PAIR_ALPHA: begin
        np[31:24] = 8'($urandom_range(1, 255));
        if (np[31:24] == op[31:24]) np[31:24] = (op[31:24] == 8'hFF) ? 8'h01 : op[31:24] + 8'h01;
      end
      PAIR_NOISE: begin
        op = $urandom();
        np = $urandom();
      end
      default: begin
      end
    endcase
    return {op, np};
  endfunction

  function automatic void push_pixel(input pair_kind_e k);
    logic [63:0] pair;
    pair = pixel_pair(k);
    push_word(MODE_PIXEL, 1'($urandom()), 16'($urandom()), 16'($urandom()),
              13'($urandom()), 13'($urandom()), pair[63:32], pair[31:0]);
  endfunction

  // Mostly well-formed old/new/pixel sequences, some noise and cut-short runs.
  task automatic random_phase(input int unsigned target);
    int unsigned      done_words;
    int unsigned      npix;
    int unsigned      cut;
    int unsigned      pick;
    logic [1:0]       mix;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    done_words = 0;
    while (done_words < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        ow = small_dim();
        oh = small_dim();
        ox = 16'($urandom());
        oy = 16'($urandom());
        push_word(MODE_OLD, 1'b1, ox, oy, ow, oh, $urandom(), $urandom());
        done_words++;
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 1) == 1) begin
            push_word(MODE_NEW, 1'b1, ox, oy, ow, oh, $urandom(), $urandom());
          end else begin
            push_word(MODE_NEW, 1'b1, 16'($urandom()), 16'($urandom()), ow, oh,
                      $urandom(), $urandom());
          end
          npix = ow * oh;
          // now and then break the run off early
          cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npix) : npix;
          mix = 2'($urandom());
          for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 15) == 0) begin
              push_word(MODE_SPARE, 1'($urandom()), 16'($urandom()), 16'($urandom()),
                        13'($urandom()), 13'($urandom()), $urandom(), $urandom());
            end
            push_pixel(pick_kind(mix));
          end
          done_words += 1 + cut;
        end
      end else if (pick == 7) begin
        push_word($urandom_range(0, 1) ? MODE_NEW : MODE_OLD, 1'($urandom()),
                  16'($urandom()), 16'($urandom()), 13'($urandom()), 13'($urandom()),
                  $urandom(), $urandom());
        done_words++;
      end else if (pick == 8) begin
        push_word($urandom_range(0, 1) ? MODE_SPARE : MODE_PIXEL, 1'($urandom()),
                  16'($urandom()), 16'($urandom()), 13'($urandom()), 13'($urandom()),
                  $urandom(), $urandom());
      end else begin
        // presence and size mismatches
        ow = small_dim();
        oh = small_dim();
        push_word(MODE_OLD, 1'($urandom()), 16'($urandom()), 16'($urandom()), ow, oh,
                  $urandom(), $urandom());
        if ($urandom_range(0, 1) == 1) begin
          ow = small_dim();
          oh = small_dim();
        end
        push_word(MODE_NEW, 1'($urandom()), 16'($urandom()), 16'($urandom()), ow, oh,
                  $urandom(), $urandom());
        done_words += 2;
      end
    end
  endtask

  // Wait until the driver is empty and every class has come back, then give
  // a trailing run-time word (no class) time to clear the pipe.
  task automatic settle();
    while (word_queue.size() != 0 || in_valid_i || kinds_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [7:0] value);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tolerance = value;
    tol_writes++;
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: words change on the falling edge; a word stays put until taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (word_queue.size() != 0) begin
        cur        <= word_queue.pop_front();
        in_valid_i <= 1'b1;
        send_gap = draw_wait(quiet_send);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: a fresh stall length after each class taken.
  always @(negedge clk) begin
    if (kind_taken) stall_left = draw_wait(quiet_recv);
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    kind_e want;
    word_taken <= rst_ni && in_valid_i && !in_stall_o;
    kind_taken <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      judge_word(cur);
      words_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kinds_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected class %0d", $time, change_kind_o);
      end else begin
        want = kinds_due.pop_front();
        kinds_checked++;
        kind_seen[want]++;
        if (change_kind_o !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: change_kind expected %0d got %0d", $time, want, change_kind_o);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed opening, tolerance still at its reset value of 20.
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'hFFFF_FFFF, 32'h0);  // stray pixel
    push_word(MODE_SPARE, 1'b1, 16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);                            // ignored mode
    push_word(MODE_NEW, 1'b0, '0, '0, '0, '0, '0, '0);                  // both absent
    push_word(MODE_NEW, 1'b1, '0, '0, 13'd1, 13'd1, '0, '0);            // old absent
    push_word(MODE_OLD, 1'b1, '0, '0, 13'd1, 13'd1, '0, '0);
    push_word(MODE_NEW, 1'b0, '0, '0, 13'd1, 13'd1, '0, '0);            // new absent
    push_word(MODE_NEW, 1'b1, '0, '0, 13'd2, 13'd1, '0, '0);            // size differs
    push_word(MODE_OLD, 1'b1, 16'd10, 16'd10, 13'd0, 13'd5, '0, '0);
    push_word(MODE_NEW, 1'b1, 16'd10, 16'd10, 13'd0, 13'd5, '0, '0);    // empty, still
    push_word(MODE_NEW, 1'b1, 16'd11, 16'd10, 13'd0, 13'd5, '0, '0);    // empty, moved
    push_word(MODE_OLD, 1'b1, 16'hFFFF, 16'hFFFF, 13'd1, 13'd2, '0, '0);
    push_word(MODE_NEW, 1'b1, 16'hFFFF, 16'hFFFF, 13'd1, 13'd2, '0, '0);
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'h00FF_FFFF, 32'h0);  // both clear
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'hFF00_0000, 32'h0);  // alpha only
    push_word(MODE_NEW, 1'b1, 16'hFFFF, 16'hFFFF, 13'd1, 13'd2, '0, '0);
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'h8010_1010, 32'h8010_1025);  // 21 off
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'hFF00_0000, 32'h0);  // after colour
    push_word(MODE_NEW, 1'b1, '0, '0, 13'd1, 13'd2, '0, '0);            // moved
    push_word(MODE_SPARE, 1'b0, '0, '0, '0, '0, '0, '0);                // mid-run, ignored
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'hFF12_3456, 32'hFF12_3456);
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'h8010_1010, 32'h8024_1010);  // 20 off
    push_word(MODE_NEW, 1'b1, '0, '0, 13'd1, 13'd2, '0, '0);
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'h4000_0000, 32'h4100_0000);  // alpha
    push_word(MODE_PIXEL, 1'b0, '0, '0, '0, '0, 32'h0, 32'h0);          // moved + alpha
    push_word(MODE_NEW, 1'b1, 16'hFFFF, 16'hFFFF, 13'd1, 13'd2, '0, '0);
    push_word(MODE_OLD, 1'b1, 16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF, '0, '0);  // abandons
    push_word(MODE_NEW, 1'b1, 16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF, '0, '0);  // oversize
    push_word(MODE_OLD, 1'b0, '0, '0, '0, '0, '0, '0);
    push_word(MODE_NEW, 1'b0, '0, '0, '0, '0, '0, '0);
    settle();

    // Random phases across the tolerance range, extremes included.
    set_tolerance(8'd0);
    random_phase(60);
    settle();
    set_tolerance(8'd255);
    random_phase(60);
    settle();
    set_tolerance(8'($urandom_range(2, 253)));
    random_phase(60);
    settle();
    // a stretch with no idling on either side
    quiet_send = 1'b1;
    quiet_recv = 1'b1;
    set_tolerance(8'd254);
    random_phase(60);
    settle();
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    set_tolerance(8'd1);
    random_phase(60);
    settle();

    // Long runs: an oversize width and a full-size square, each abandoned
    // part way, then an oversize empty area.
    set_tolerance(TOL_RESET);
    push_word(MODE_OLD, 1'b1, 16'h1234, 16'h0040, 13'd5000, 13'd1, '0, '0);
    push_word(MODE_NEW, 1'b1, 16'h1234, 16'h0040, 13'd5000, 13'd1, '0, '0);
    for (int i = 0; i < 40; i++) push_pixel(pick_kind(2'b01));
    push_word(MODE_OLD, 1'b1, '0, '0, 13'd4096, 13'd4096, '0, '0);
    push_word(MODE_NEW, 1'b1, 16'd1, '0, 13'd4096, 13'd4096, '0, '0);
    for (int i = 0; i < 30; i++) push_pixel(pick_kind(2'b00));
    push_word(MODE_OLD, 1'b1, 16'd7, 16'd7, 13'h1FFF, 13'd0, '0, '0);
    push_word(MODE_NEW, 1'b1, 16'd7, 16'd8, 13'h1FFF, 13'd0, '0, '0);
    settle();

    $display("%0d words taken, %0d classes checked (none %0d, position %0d, alpha %0d, content %0d)",
             words_in, kinds_checked, kind_seen[KIND_NONE], kind_seen[KIND_POSITION],
             kind_seen[KIND_ALPHA], kind_seen[KIND_CONTENT]);
    $display("%0d tolerance writes from 0 to 255, oversize runs abandoned part way",
             tol_writes);
    if (errors == 0 && kinds_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
